/* sv/ssap_pkg.sv */
// Shared constants, payload types and rate tables of the sensor sample aggregator.
package ssap_pkg;

  // Ring, store and timing constants.
  localparam int RING_SAMPLES       = 6;
  localparam int SAMPLE_PERIOD_SECS = 10;
  localparam int STORE_DEPTH        = 5;
  localparam int RATE_COUNT         = 7;

  // Field widths.
  localparam int RATE_W = 3;
  localparam int CO2_W  = 16;
  localparam int TEMP_W = 12;
  localparam int HUM_W  = 11;
  localparam int BUF_W  = 16;
  localparam int BYTE_W = 8;

  // Request kinds carried in the func field.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_ENCODE = 1'b1;

  // Derived widths.
  localparam int RING_IDX_W  = (RING_SAMPLES > 1) ? $clog2(RING_SAMPLES) : 1;
  localparam int CO2_MAX     = (1 << CO2_W) - 1;
  localparam int TEMP_MAG    = 1 << (TEMP_W - 1);
  localparam int HUM_MAX     = (1 << HUM_W) - 1;
  localparam int CO2_SUM_W   = $clog2(RING_SAMPLES * CO2_MAX + RING_SAMPLES / 2 + 1);
  localparam int TEMP_MAG_W  = $clog2(RING_SAMPLES * TEMP_MAG + 1);
  localparam int TEMP_SUM_W  = TEMP_MAG_W + 1;
  localparam int HUM_SUM_W   = $clog2(RING_SAMPLES * HUM_MAX + 1);
  localparam int DIV_W       = CO2_SUM_W;
  localparam int DVS_MAX     = (RING_SAMPLES > 20) ? RING_SAMPLES : 20;
  localparam int DVS_W       = $clog2(DVS_MAX + 1);
  localparam int MAX_PERIOD  = 14 * 60;
  localparam int SECS_W      = $clog2(MAX_PERIOD + SAMPLE_PERIOD_SECS + 1);
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W       = $clog2(2 * STORE_DEPTH + 2);

  // Packing constants.
  localparam int CO2_STEP     = 20;
  localparam int CO2_BIAS     = 10;
  localparam int HUM_STEP     = 10;
  localparam int HUM_BIAS     = 5;
  localparam int TEMP_BIAS    = 8;

  // Reciprocals for the shared multiplier. The quotient (n * ceil(2^s / d)) >> s is exact
  // for every dividend below 2^DIV_W, because every divisor stays below 2^DVS_W.
  localparam int     RECIP_SHIFT = DIV_W + DVS_W;
  localparam int     RECIP_W     = RECIP_SHIFT + 1;
  localparam int     PROD_W      = DIV_W + RECIP_W;
  localparam longint RECIP_ONE   = longint'(1) << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_AVG =
    RECIP_W'((RECIP_ONE + RING_SAMPLES - 1) / RING_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP_CO2 = RECIP_W'((RECIP_ONE + CO2_STEP - 1) / CO2_STEP);
  localparam logic [RECIP_W-1:0] RECIP_HUM = RECIP_W'((RECIP_ONE + HUM_STEP - 1) / HUM_STEP);

  // Input request.
  typedef struct packed {
    logic                     func;
    logic                     sensor_failed;
    logic [CO2_W-1:0]         co2_ppm;
    logic signed [TEMP_W-1:0] temperature_q4;
    logic [HUM_W-1:0]         humidity_q4;
    logic [BUF_W-1:0]         buffer_size;
  } in_t;

  // Result request.
  typedef struct packed {
    logic              reading_valid;
    logic [CO2_W-1:0]  co2_reading;
    logic              sample_queued;
    logic              dropped_oldest;
    logic              message_due;
    logic [BYTE_W-1:0] message_byte;
    logic [LEN_W-1:0]  message_length;
    logic              last;
  } out_t;

  // One sample held in the ring.
  typedef struct packed {
    logic [CO2_W-1:0]         co2;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
  } ring_entry_t;

  // Divider command and answer.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [RECIP_W-1:0] recip;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Sampling period in seconds for each data rate.
  function automatic logic [SECS_W-1:0] period_secs(input logic [RATE_W-1:0] rate);
    logic [SECS_W-1:0] p;
    case (rate)
      3'd1:    p = SECS_W'(9 * 60);
      3'd2:    p = SECS_W'(3 * 60);
      3'd3:    p = SECS_W'(3 * 60);
      3'd4:    p = SECS_W'(2 * 60);
      3'd5:    p = SECS_W'(1 * 60);
      3'd6:    p = SECS_W'(1 * 60);
      default: p = SECS_W'(14 * 60);
    endcase
    return p;
  endfunction

  // Averages per message for each data rate.
  function automatic logic [CNT_W-1:0] per_message(input logic [RATE_W-1:0] rate);
    logic [CNT_W-1:0] n;
    case (rate)
      3'd1:    n = CNT_W'(4);
      3'd2:    n = CNT_W'(5);
      3'd3:    n = CNT_W'(3);
      3'd4:    n = CNT_W'(2);
      3'd5:    n = CNT_W'(2);
      3'd6:    n = CNT_W'(2);
      default: n = CNT_W'(5);
    endcase
    return n;
  endfunction

endpackage

/* sv/ssap_divu.sv */
// Shared reciprocal multiplier that divides by the constant divisors of the averaging and packing steps.
module ssap_divu import ssap_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  logic [DIV_W-1:0]   dvd_r;
  logic [RECIP_W-1:0] rcp_r;
  logic [PROD_W-1:0]  prod_r;

  // Operand registers, product register, then a completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= req.start;
      done_r <= busy_r;
    end
  end

  // Operand registers and product.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rcp_r <= req.recip;
    end
    if (busy_r) begin
      prod_r <= PROD_W'(dvd_r) * PROD_W'(rcp_r);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = prod_r[RECIP_SHIFT +: DIV_W];

endmodule

/* sv/sensor_sample_aggregator_packer.sv */
// Top level: sample ring, seconds counter, averaging sequencer, message store and encoder.
//
// Each good sensor sample request is written into a ring of the six most recent samples and
// advances a seconds counter by ten. When the sampling period of the current data rate is
// reached, the sequencer walks the ring (one entry per cycle) and then runs five divisions
// (ring averages and the packing steps) on one shared reciprocal multiplier, one after
// another. The packed average goes into a five-entry circular store, dropping the
// oldest entry when the store holds a full message. An encode request gives one result
// per cycle while the output is not stalled: a header byte and two bytes per stored
// average (1 + 2 x count results), or a single zero-length result when no message is due
// or the buffer is too small. The block takes no new request until the current one has
// handed over its last result to the output register. The ring clears at reset; the
// store needs no clearing.
module sensor_sample_aggregator_packer import ssap_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SUM      = 3'd1;
  localparam logic [2:0] ST_DIV_GO   = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT = 3'd3;
  localparam logic [2:0] ST_APPEND   = 3'd4;
  localparam logic [2:0] ST_RESP     = 3'd5;
  localparam logic [2:0] ST_ENC      = 3'd6;

  // Division steps.
  localparam logic [2:0] OP_CO2_AVG  = 3'd0;
  localparam logic [2:0] OP_CO2_BYTE = 3'd1;
  localparam logic [2:0] OP_TEMP_AVG = 3'd2;
  localparam logic [2:0] OP_HUM_AVG  = 3'd3;
  localparam logic [2:0] OP_HUM_BYTE = 3'd4;

  function automatic logic [STORE_IDX_W-1:0] store_wrap(input logic [STORE_IDX_W-1:0] a,
                                                        input logic [STORE_IDX_W-1:0] b);
    logic [STORE_IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (STORE_IDX_W + 1)'(STORE_DEPTH)) begin
      s = s - (STORE_IDX_W + 1)'(STORE_DEPTH);
    end
    return s[STORE_IDX_W-1:0];
  endfunction

  // Control state.
  logic [2:0]            state_r;
  logic [2:0]            op_r;
  logic [RATE_W-1:0]     datarate_r;
  logic [RING_IDX_W-1:0] pos_r;
  logic [RING_IDX_W-1:0] walk_r;
  logic [SECS_W-1:0]     secs_r;
  logic [STORE_IDX_W-1:0] head_r;
  logic [CNT_W-1:0]      count_r;
  logic [LEN_W-1:0]      bc_r;
  logic                  out_valid_r;

  // Datapath state.
  ring_entry_t              ring_r [RING_SAMPLES];
  logic [2*BYTE_W-1:0]      store_r [STORE_DEPTH];
  logic [CO2_SUM_W-1:0]     sum_co2_r;
  logic signed [TEMP_SUM_W-1:0] sum_temp_r;
  logic [HUM_SUM_W-1:0]     sum_hum_r;
  logic [CO2_W-1:0]         avg_co2_r;
  logic signed [TEMP_W-1:0] avg_temp_r;
  logic [HUM_W-1:0]         avg_hum_r;
  logic [BYTE_W-1:0]        co2_byte_r;
  logic [2:0]               hum3_r;
  logic [CO2_W-1:0]         co2_r;
  logic                     resp_ok_r;
  logic                     queued_r;
  logic                     dropped_r;
  logic [LEN_W-1:0]         len_r;
  out_t                     out_data_r;

  // Combinational signals.
  logic                  in_accept;
  logic                  sample_ok;
  logic                  out_free;
  logic                  out_load;
  logic [CNT_W-1:0]      per_msg;
  logic                  due;
  logic [LEN_W-1:0]      len_now;
  logic                  enc_ok;
  logic [SECS_W-1:0]     secs_add;
  logic                  period_hit;
  logic [RING_IDX_W-1:0] pos_next;
  logic                  walk_last;
  ring_entry_t           sample;
  ring_entry_t           walk_entry;
  logic                  temp_neg;
  logic [TEMP_SUM_W-1:0] temp_neg_sum;
  logic [TEMP_MAG_W-1:0] temp_mag;
  logic [TEMP_W-1:0]     temp_q;
  logic signed [TEMP_W:0] t_biased;
  logic [4:0]            t5;
  logic                  drop;
  logic [STORE_IDX_W-1:0] head_d;
  logic [CNT_W-1:0]      cnt_d;
  logic                  queue;
  logic [STORE_IDX_W-1:0] wr_idx;
  logic [LEN_W-1:0]      bc_m1;
  logic [STORE_IDX_W-1:0] rd_idx;
  logic [2*BYTE_W-1:0]   rd_entry;
  logic                  enc_last;
  logic [BYTE_W-1:0]     enc_byte;
  out_t                  resp_out;
  out_t                  enc_out;
  out_t                  out_nxt;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // Handshake and request decode.
  always_comb begin
    in_stall   = state_r != ST_IDLE;
    in_accept  = in_valid && !in_stall;
    sample_ok  = (in_data.func == FUNC_SAMPLE) && !in_data.sensor_failed;
    out_free   = !out_valid_r || !out_stall;
    out_load   = out_free && ((state_r == ST_RESP) || (state_r == ST_ENC));
    per_msg    = per_message(datarate_r);
    due        = count_r >= per_msg;
    len_now    = LEN_W'({count_r, 1'b0}) + LEN_W'(1);
    enc_ok     = due && (in_data.buffer_size != '0) &&
                 (BUF_W'(len_now) <= in_data.buffer_size);
    secs_add   = secs_r + SECS_W'(SAMPLE_PERIOD_SECS);
    period_hit = secs_add >= period_secs(datarate_r);
    pos_next   = (pos_r == RING_IDX_W'(RING_SAMPLES - 1)) ? '0 : pos_r + RING_IDX_W'(1);
    walk_last  = walk_r == RING_IDX_W'(RING_SAMPLES - 1);
    walk_entry = ring_r[walk_r];
    sample.co2  = in_data.co2_ppm;
    sample.temp = in_data.temperature_q4;
    sample.hum  = in_data.humidity_q4;
  end

  // Divider operand selection.
  always_comb begin
    temp_neg     = sum_temp_r[TEMP_SUM_W-1];
    temp_neg_sum = -sum_temp_r;
    temp_mag     = temp_neg ? temp_neg_sum[TEMP_MAG_W-1:0] : sum_temp_r[TEMP_MAG_W-1:0];
    div_req.start = state_r == ST_DIV_GO;
    case (op_r)
      OP_CO2_AVG:  div_req.dividend = DIV_W'(sum_co2_r) + DIV_W'(RING_SAMPLES / 2);
      OP_CO2_BYTE: div_req.dividend = DIV_W'(avg_co2_r) + DIV_W'(CO2_BIAS);
      OP_TEMP_AVG: div_req.dividend = DIV_W'(temp_mag);
      OP_HUM_AVG:  div_req.dividend = DIV_W'(sum_hum_r);
      OP_HUM_BYTE: div_req.dividend = DIV_W'(avg_hum_r >> 4) + DIV_W'(HUM_BIAS);
      default:     div_req.dividend = '0;
    endcase
    case (op_r) inside
      OP_CO2_BYTE: div_req.recip = RECIP_CO2;
      OP_HUM_BYTE: div_req.recip = RECIP_HUM;
      default:     div_req.recip = RECIP_AVG;
    endcase
    temp_q = div_rsp.quotient[TEMP_W-1:0];
  end

  ssap_divu u_divu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Temperature packing: floor((t + 8) / 16), low five bits.
  always_comb begin
    t_biased = {avg_temp_r[TEMP_W-1], avg_temp_r} + (TEMP_W + 1)'(TEMP_BIAS);
    t5       = t_biased[8:4];
  end

  // Store append with drop of the oldest entry.
  always_comb begin
    drop   = count_r >= per_msg;
    head_d = drop ? store_wrap(head_r, STORE_IDX_W'(1)) : head_r;
    cnt_d  = drop ? count_r - CNT_W'(1) : count_r;
    queue  = cnt_d < CNT_W'(STORE_DEPTH);
    wr_idx = store_wrap(head_d, cnt_d[STORE_IDX_W-1:0]);
  end

  // Encoder byte selection.
  always_comb begin
    bc_m1    = bc_r - LEN_W'(1);
    rd_idx   = store_wrap(head_r, bc_m1[STORE_IDX_W:1]);
    rd_entry = store_r[rd_idx];
    enc_last = bc_r == len_r - LEN_W'(1);
    if (bc_r == '0) begin
      enc_byte = BYTE_W'(per_msg) - BYTE_W'(1);
    end else if (bc_r[0]) begin
      enc_byte = rd_entry[2*BYTE_W-1:BYTE_W];
    end else begin
      enc_byte = rd_entry[BYTE_W-1:0];
    end
  end

  // Result formatting.
  always_comb begin
    resp_out.reading_valid  = resp_ok_r;
    resp_out.co2_reading    = co2_r;
    resp_out.sample_queued  = queued_r;
    resp_out.dropped_oldest = dropped_r;
    resp_out.message_due    = due;
    resp_out.message_byte   = '0;
    resp_out.message_length = '0;
    resp_out.last           = 1'b1;

    enc_out.reading_valid  = 1'b0;
    enc_out.co2_reading    = '0;
    enc_out.sample_queued  = 1'b0;
    enc_out.dropped_oldest = 1'b0;
    enc_out.message_due    = 1'b1;
    enc_out.message_byte   = enc_byte;
    enc_out.message_length = len_r;
    enc_out.last           = enc_last;

    out_nxt = (state_r == ST_ENC) ? enc_out : resp_out;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      datarate_r <= '0;
    end else if (cfg_wr_en) begin
      datarate_r <= (cfg_wr_data < RATE_W'(RATE_COUNT)) ? cfg_wr_data : '0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_CO2_AVG;
      walk_r      <= '0;
      pos_r       <= '0;
      secs_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            walk_r <= '0;
            bc_r   <= '0;
            op_r   <= OP_CO2_AVG;
            if (in_data.func == FUNC_SAMPLE) begin
              if (sample_ok) begin
                pos_r   <= pos_next;
                secs_r  <= period_hit ? '0 : secs_add;
                state_r <= period_hit ? ST_SUM : ST_RESP;
              end else begin
                state_r <= ST_RESP;
              end
            end else begin
              state_r <= enc_ok ? ST_ENC : ST_RESP;
            end
          end
        end
        ST_SUM: begin
          walk_r <= walk_r + RING_IDX_W'(1);
          if (walk_last) begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (op_r == OP_HUM_BYTE) begin
              state_r <= ST_APPEND;
            end else begin
              op_r    <= op_r + 3'd1;
              state_r <= ST_DIV_GO;
            end
          end
        end
        ST_APPEND: begin
          head_r  <= head_d;
          count_r <= queue ? cnt_d + CNT_W'(1) : cnt_d;
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_ENC: begin
          if (out_free) begin
            bc_r <= bc_r + LEN_W'(1);
            if (enc_last) begin
              count_r <= '0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample ring, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_SAMPLES; i++) begin
        ring_r[i] <= '0;
      end
    end else if (in_accept && sample_ok) begin
      ring_r[pos_r] <= sample;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      co2_r      <= sample_ok ? in_data.co2_ppm : '0;
      resp_ok_r  <= sample_ok;
      queued_r   <= 1'b0;
      dropped_r  <= 1'b0;
      len_r      <= len_now;
      sum_co2_r  <= '0;
      sum_temp_r <= '0;
      sum_hum_r  <= '0;
    end
    if (state_r == ST_SUM) begin
      sum_co2_r  <= sum_co2_r + CO2_SUM_W'(walk_entry.co2);
      sum_temp_r <= sum_temp_r + TEMP_SUM_W'(walk_entry.temp);
      sum_hum_r  <= sum_hum_r + HUM_SUM_W'(walk_entry.hum);
    end
    if ((state_r == ST_DIV_WAIT) && div_rsp.done) begin
      case (op_r)
        OP_CO2_AVG:  avg_co2_r  <= div_rsp.quotient[CO2_W-1:0];
        OP_CO2_BYTE: co2_byte_r <= div_rsp.quotient[BYTE_W-1:0];
        OP_TEMP_AVG: avg_temp_r <= temp_neg ? -temp_q : temp_q;
        OP_HUM_AVG:  avg_hum_r  <= div_rsp.quotient[HUM_W-1:0];
        OP_HUM_BYTE: hum3_r     <= div_rsp.quotient[2:0];
        default:     hum3_r     <= hum3_r;
      endcase
    end
    if (state_r == ST_APPEND) begin
      queued_r  <= queue;
      dropped_r <= drop;
      if (queue) begin
        store_r[wr_idx] <= {co2_byte_r, t5, hum3_r};
      end
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The store pointers stay inside the store.
  a_store_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(STORE_DEPTH)) && (head_r < STORE_IDX_W'(STORE_DEPTH)))
    else $error("message store count or head out of range");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside of a division step");

  // Encoding only runs on a due message.
  a_enc_due: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENC) |-> due)
    else $error("encoding without a due message");

  // A message byte never carries sample status.
  a_msg_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.message_length != '0)) |->
      (out_data_r.message_due && !out_data_r.reading_valid))
    else $error("message byte result with inconsistent status");

endmodule

/* sim/tb_sensor_sample_aggregator_packer.sv */
// Self-checking testbench for the sensor sample aggregator: directed and random requests
// are scored against a behavioral model of the ring averages, message store and encoder.
module tb_sensor_sample_aggregator_packer;
  timeunit 1ns;
  timeprecision 1ps;
  import ssap_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 4;
  localparam int QUIET_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 150;
  localparam int MAX_REPORTS  = 10;

  // Register value that is out of range and must fall back to the slowest rate.
  localparam logic [RATE_W-1:0] RATE_ILLEGAL = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_wr_en = 1'b0;
  logic [RATE_W-1:0] cfg_wr_data = '0;

  sensor_sample_aggregator_packer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Model state: one reading in full precision.
  typedef struct {
    int unsigned co2;
    int          temp;
    int unsigned hum;
  } reading_t;

  reading_t    ring [RING_SAMPLES];
  reading_t    averages [STORE_DEPTH];
  int unsigned ring_pos;
  int unsigned secs_elapsed;
  int unsigned stored;
  int unsigned rate_sel;

  in_t  pending [$];
  out_t reply_q [$];

  logic took_in = 1'b0;
  int   idle_pct = 15;
  int   quiet_cycles = 0;
  int   errors = 0;
  int   request_cnt = 0;
  int   result_cnt = 0;
  int   encode_cnt = 0;
  int   failed_cnt = 0;
  int   avg_cnt = 0;
  int   drop_cnt = 0;
  int   msg_cnt = 0;

  // Sampling period in seconds for a data rate; anything out of range acts as rate 0.
  function automatic int unsigned period_of(int unsigned rate);
    case (rate)
      1:       return 9 * 60;
      2, 3:    return 3 * 60;
      4:       return 2 * 60;
      5, 6:    return 1 * 60;
      default: return 14 * 60;
    endcase
  endfunction

  // Number of averages that make up one message.
  function automatic int unsigned batch_of(int unsigned rate);
    case (rate)
      1:       return 4;
      3:       return 3;
      4, 5, 6: return 2;
      default: return 5;
    endcase
  endfunction

  function automatic out_t make_reply(logic valid, logic [CO2_W-1:0] co2, logic queued,
                                      logic dropped, logic due, logic [BYTE_W-1:0] msg_byte,
                                      int unsigned len, logic last_flag);
    out_t r;
    r.reading_valid  = valid;
    r.co2_reading    = co2;
    r.sample_queued  = queued;
    r.dropped_oldest = dropped;
    r.message_due    = due;
    r.message_byte   = msg_byte;
    r.message_length = LEN_W'(len);
    r.last           = last_flag;
    return r;
  endfunction

  // Mean over the whole ring; CO2 rounds to nearest, the Q4 values truncate toward zero.
  function automatic reading_t ring_mean();
    int unsigned sc;
    int unsigned sh;
    int          st;
    reading_t    m;
    sc = 0;
    sh = 0;
    st = 0;
    foreach (ring[i]) begin
      sc += ring[i].co2;
      st += ring[i].temp;
      sh += ring[i].hum;
    end
    m.co2  = (sc + RING_SAMPLES / 2) / RING_SAMPLES;
    m.temp = st / RING_SAMPLES;
    m.hum  = sh / RING_SAMPLES;
    return m;
  endfunction

  // Second packed byte: whole degrees (rounded, floor for negatives) and humidity tens.
  function automatic logic [BYTE_W-1:0] climate_byte(reading_t e);
    int          v;
    int          deg;
    int unsigned h;
    v   = e.temp + 8;
    deg = (v >= 0) ? v / 16 : -((-v + 15) / 16);
    h   = (e.hum / 16 + 5) / 10;
    return {deg[4:0], h[2:0]};
  endfunction

  // Advance the model by one accepted request and queue the results it must produce.
  task automatic absorb_request(input in_t req);
    reading_t    s;
    logic        queued;
    logic        dropped;
    int unsigned len;
    int unsigned batch;
    batch = batch_of(rate_sel);
    if (req.func == FUNC_SAMPLE) begin
      if (req.sensor_failed) begin
        failed_cnt++;
        reply_q.push_back(make_reply(0, '0, 0, 0, stored >= batch, '0, 0, 1));
      end else begin
        queued  = 1'b0;
        dropped = 1'b0;
        s.co2   = req.co2_ppm;
        s.temp  = int'($signed(req.temperature_q4));
        s.hum   = req.humidity_q4;
        ring[ring_pos] = s;
        ring_pos = (ring_pos + 1) % RING_SAMPLES;
        secs_elapsed += SAMPLE_PERIOD_SECS;
        if (secs_elapsed >= period_of(rate_sel)) begin
          // A full message already waits: the oldest average makes room.
          if (stored >= batch) begin
            for (int i = 0; i + 1 < stored; i++) begin
              averages[i] = averages[i + 1];
            end
            stored--;
            dropped = 1'b1;
            drop_cnt++;
          end
          if (stored < STORE_DEPTH) begin
            averages[stored] = ring_mean();
            stored++;
            queued = 1'b1;
            avg_cnt++;
          end
          secs_elapsed = 0;
        end
        reply_q.push_back(make_reply(1, req.co2_ppm, queued, dropped, stored >= batch,
                                     '0, 0, 1));
      end
    end else begin
      encode_cnt++;
      len = 1 + 2 * stored;
      if (stored < batch || req.buffer_size == 0 || len > req.buffer_size) begin
        reply_q.push_back(make_reply(0, '0, 0, 0, stored >= batch, '0, 0, 1));
      end else begin
        // Header first, then CO2 and climate bytes per stored average.
        reply_q.push_back(make_reply(0, '0, 0, 0, 1, BYTE_W'(batch - 1), len, len == 1));
        for (int i = 0; i < stored; i++) begin
          reply_q.push_back(make_reply(0, '0, 0, 0, 1,
                                       BYTE_W'((averages[i].co2 + 10) / 20), len, 0));
          reply_q.push_back(make_reply(0, '0, 0, 0, 1, climate_byte(averages[i]), len,
                                       i + 1 == stored));
        end
        stored = 0;
        msg_cnt++;
      end
    end
  endtask

  function automatic string show(out_t r);
    return $sformatf("valid=%0b co2=%0d queued=%0b dropped=%0b due=%0b byte=%02h len=%0d last=%0b",
                     r.reading_valid, r.co2_reading, r.sample_queued, r.dropped_oldest,
                     r.message_due, r.message_byte, r.message_length, r.last);
  endfunction

  // Score one result against the oldest expectation.
  task automatic compare_reply(input out_t got);
    out_t want;
    if (reply_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) $display("Unexpected result: %s", show(got));
    end else begin
      want = reply_q.pop_front();
      if (got.reading_valid !== want.reading_valid || got.co2_reading !== want.co2_reading ||
          got.sample_queued !== want.sample_queued ||
          got.dropped_oldest !== want.dropped_oldest ||
          got.message_due !== want.message_due || got.message_byte !== want.message_byte ||
          got.message_length !== want.message_length || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Mismatch at %0t: expected %s", $realtime, show(want));
          $display("                 actual   %s", show(got));
        end
      end
    end
  endtask

  // Rising edge: model reset, register writes, result checking and request prediction.
  always @(posedge clk) begin
    took_in = 1'b0;
    if (!rst_n) begin
      foreach (ring[i]) ring[i] = '{0, 0, 0};
      ring_pos     = 0;
      secs_elapsed = 0;
      stored       = 0;
      rate_sel     = 0;
    end else begin
      if (cfg_wr_en) rate_sel = (cfg_wr_data < RATE_COUNT) ? cfg_wr_data : 0;
      if (out_valid && !out_stall) begin
        compare_reply(out_data);
        result_cnt++;
      end
      if (in_valid && !in_stall) begin
        absorb_request(in_data);
        took_in = 1'b1;
        request_cnt++;
      end
      quiet_cycles = (took_in || (out_valid && !out_stall)) ? 0 : quiet_cycles + 1;
    end
  end

  // Falling edge: present the next request once the current one is taken, with random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took_in)) begin
      if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
  end

  task automatic queue_request(input logic func, input logic failed,
                               input logic [CO2_W-1:0] co2, input logic [TEMP_W-1:0] temp,
                               input logic [HUM_W-1:0] hum, input logic [BUF_W-1:0] buf_size);
    in_t req;
    req.func           = func;
    req.sensor_failed  = failed;
    req.co2_ppm        = co2;
    req.temperature_q4 = temp;
    req.humidity_q4    = hum;
    req.buffer_size    = buf_size;
    pending.push_back(req);
  endtask

  // Mostly good samples in the sensor range, some failures, out-of-range values and encodes.
  function automatic in_t random_request();
    in_t req;
    int  t;
    req.buffer_size = BUF_W'($urandom());
    req.co2_ppm     = CO2_W'($urandom());
    if ($urandom_range(99) < 85) begin
      t = int'($urandom_range(1920)) - 640;
      req.temperature_q4 = TEMP_W'(t);
      req.humidity_q4    = HUM_W'($urandom_range(1600));
    end else begin
      req.temperature_q4 = TEMP_W'($urandom());
      req.humidity_q4    = HUM_W'($urandom());
    end
    if ($urandom_range(99) < 12) begin
      req.func          = FUNC_ENCODE;
      req.sensor_failed = 1'($urandom());
      if ($urandom_range(99) < 70) req.buffer_size = BUF_W'($urandom_range(65535, 11));
      else req.buffer_size = BUF_W'($urandom_range(12));
    end else begin
      req.func          = FUNC_SAMPLE;
      req.sensor_failed = ($urandom_range(99) < 8);
    end
    return req;
  endfunction

  // Wait until every request is taken and every expected result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_valid || reply_q.size() != 0);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_rate(input logic [RATE_W-1:0] rate);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(input logic [RATE_W-1:0] rate, input int count, input int pct);
    set_rate(rate);
    idle_pct = pct;
    repeat (count) pending.push_back(random_request());
  endtask

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog: no request moved for %0d cycles.", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: encodes with nothing due, a failed sample and field extremes at reset rate.
    queue_request(FUNC_ENCODE, 0, 16'h0000, 12'h000, 11'h000, 16'h0000);
    queue_request(FUNC_ENCODE, 1, 16'hFFFF, 12'hFFF, 11'h7FF, 16'hFFFF);
    queue_request(FUNC_SAMPLE, 1, 16'hFFFF, 12'h7FF, 11'h7FF, 16'hFFFF);
    queue_request(FUNC_SAMPLE, 0, 16'h0000, -12'sd640, 11'd0, 16'h0000);
    queue_request(FUNC_SAMPLE, 0, 16'hFFFF, 12'sd1280, 11'd1600, 16'h0000);
    queue_request(FUNC_SAMPLE, 0, 16'h1234, 12'h800, 11'h7FF, 16'h00FF);
    queue_request(FUNC_SAMPLE, 0, 16'h8000, 12'h7FF, 11'h400, 16'hFF00);
    queue_request(FUNC_SAMPLE, 0, 16'h5555, 12'h555, 11'h2AA, 16'hAAAA);
    queue_request(FUNC_SAMPLE, 0, 16'hAAAA, 12'hAAA, 11'h555, 16'h5555);

    // Fastest rate with seconds carried over: an immediate average, then a full message that
    // drops its oldest entry, then a buffer one byte short and one that fits exactly.
    set_rate(3'd6);
    for (int k = 0; k < 13; k++) begin
      queue_request(FUNC_SAMPLE, 0, k[0] ? 16'hFFFF : 16'h0000,
                    k[0] ? 12'sd1280 : -12'sd640, k[0] ? 11'd1600 : 11'd0, 16'h0000);
    end
    queue_request(FUNC_ENCODE, 0, 16'h0000, 12'h000, 11'h000, 16'd4);
    queue_request(FUNC_ENCODE, 0, 16'h0000, 12'h000, 11'h000, 16'd5);

    // Random phases over every rate setting; one phase runs without any gaps or stalls.
    random_phase(3'd6, 30, 15);
    random_phase(3'd4, 45, 15);
    random_phase(3'd3, 40, 0);
    random_phase(3'd2, 40, 15);
    random_phase(3'd5, 40, 15);
    random_phase(RATE_ILLEGAL, 25, 15);
    random_phase(3'd1, 60, 15);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    errors += reply_q.size();

    $display("Covered %0d requests (%0d encodes, %0d failed samples) and %0d results over all data rates.",
             request_cnt, encode_cnt, failed_cnt, result_cnt);
    $display("Averages queued: %0d, oldest dropped: %0d, messages packed: %0d, mismatches: %0d.",
             avg_cnt, drop_cnt, msg_cnt, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
